// ===== src/evl_pkg.sv =====
// Package with the shared types, codes and defaults of the event ledger ring.
`timescale 1ns / 1ps

package evl_pkg;

  localparam int RING_DEPTH_DEF   = 64;
  localparam int PAYLOAD_BITS_DEF = 32;

  // Command codes; the remaining codes only return status.
  localparam logic [2:0] CMD_APPEND = 3'd0;
  localparam logic [2:0] CMD_REPORT = 3'd1;
  localparam logic [2:0] CMD_TAKE   = 3'd2;
  localparam logic [2:0] CMD_COMMIT = 3'd3;
  localparam logic [2:0] CMD_READ   = 3'd4;

  // Event kinds.
  localparam logic [1:0] KIND_WINDOW = 2'd0;
  localparam logic [1:0] KIND_FRONT  = 2'd1;
  localparam logic [1:0] KIND_MENU   = 2'd2;
  localparam logic [1:0] KIND_OTHER  = 2'd3;

  typedef struct packed {
    logic [2:0]  command;
    logic [1:0]  event_kind;
    logic [31:0] record_payload;
    logic [31:0] source_lost;
    logic [31:0] source_dropped_total;
    logic [31:0] cursor_value;
  } evl_cmd_t;

  typedef struct packed {
    logic        taken;
    logic [31:0] generation;
    logic [31:0] structure_gen;
    logic [31:0] front_gen;
    logic [31:0] menu_gen;
    logic [31:0] gap_gen;
    logic [31:0] lost_count;
    logic [31:0] write_pos;
    logic [31:0] read_pos;
    logic [31:0] dropped_count;
    logic [1:0]  entry_kind;
    logic [31:0] entry_payload;
  } evl_res_t;

  // Status of the slot reduction unit.
  typedef struct packed {
    logic busy;
    logic done;
  } evl_mod_stat_t;

endpackage

// ===== src/evl_stream_if.sv =====
// Valid/ready stream interface that carries one payload per transfer.
`timescale 1ns / 1ps

interface evl_stream_if #(
  parameter type payload_t = logic [0:0]
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/evl_mod_unit.sv =====
// Multi-cycle reduction of a 32-bit cursor to its ring slot (cursor modulo depth).
`timescale 1ns / 1ps

module evl_mod_unit #(
  parameter int RING_DEPTH = evl_pkg::RING_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [31:0]                   value_i,
  output evl_pkg::evl_mod_stat_t        stat_o,
  output logic [$clog2(RING_DEPTH)-1:0] rem_o
);
  import evl_pkg::*;

  localparam int SLOT_W = $clog2(RING_DEPTH);
  localparam int SHIFT  = 32 + SLOT_W;
  // Rounded-up reciprocal of the depth; the product with any 32-bit value,
  // shifted right by SHIFT, is the exact quotient.
  localparam logic [63:0] RECIP_W =
    ((64'd1 << SHIFT) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH);
  localparam logic [32:0]     RECIP   = RECIP_W[32:0];
  localparam logic [SLOT_W:0] DEPTH_W = (SLOT_W+1)'(RING_DEPTH);

  localparam logic [1:0] PH_LO   = 2'd0;
  localparam logic [1:0] PH_QUOT = 2'd1;
  localparam logic [1:0] PH_REM  = 2'd2;

  logic [31:0]       val_q;
  logic [48:0]       lo_q, lo_d;
  logic [48:0]       hi_prod;
  logic [64:0]       prod_sum;
  logic [64:0]       quot_wide;
  logic [31:0]       quot_q, quot_d;
  logic [2*SLOT_W:0] back_prod;
  logic [SLOT_W-1:0] rem_q, rem_d;
  logic [1:0]        phase_q;
  logic              busy_q, done_q;

  // Low half product first, then the high half and the quotient, then the
  // remainder from the low bits of value minus quotient times depth.
  assign lo_d      = 49'(val_q[15:0]) * 49'(RECIP);
  assign hi_prod   = 49'(val_q[31:16]) * 49'(RECIP);
  assign prod_sum  = {hi_prod, 16'd0} + {16'd0, lo_q};
  assign quot_wide = prod_sum >> SHIFT;
  assign quot_d    = quot_wide[31:0];
  assign back_prod = (2*SLOT_W+1)'(quot_q[SLOT_W-1:0]) * (2*SLOT_W+1)'(DEPTH_W);
  assign rem_d     = val_q[SLOT_W-1:0] - back_prod[SLOT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= PH_LO;
    end else if (start_i) begin
      busy_q  <= 1'b1;
      done_q  <= 1'b0;
      phase_q <= PH_LO;
    end else if (busy_q) begin
      phase_q <= phase_q + 2'd1;
      if (phase_q == PH_REM) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q <= value_i;
    end
    if (busy_q) begin
      case (phase_q)
        PH_LO: begin
          lo_q <= lo_d;
        end
        PH_QUOT: begin
          quot_q <= quot_d;
        end
        default: begin
          rem_q <= rem_d;
        end
      endcase
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign rem_o       = rem_q;

endmodule

// ===== src/event_ledger_ring_with_generations.sv =====
// Top level of the event ledger ring with per-domain generation counters.
`timescale 1ns / 1ps

// Usage: commands arrive on in_i and every command yields exactly one result
// on out_o; a transfer happens on a clock edge with valid and ready high.
// Append, source report, take invalidation, commit and the unused codes are
// executed in the cycle they are accepted, and the result sits in the output
// register from the next cycle on, so these commands sustain one per cycle
// while the receiver takes each result. A read-entry command first reduces
// its cursor to a slot in a reduction unit that multiplies by the reciprocal
// of the depth, then reads the ring memory, then loads the output register
// once that is free; only after that does the block take its next command.
// The ring is one synchronous memory of kind and payload, written by appends.
// Slots that were never written read as zero: a fill flag and the write slot
// tell written slots apart, so no clearing pass is needed after reset.
// Reset (rst_ni low) clears all cursors, counters, the baseline binding and
// the output valid flag at once. When the receiver stalls, the result stays in
// the output register and in_i.ready drops until that result is transferred.
module event_ledger_ring_with_generations #(
  parameter int RING_DEPTH   = evl_pkg::RING_DEPTH_DEF,
  parameter int PAYLOAD_BITS = evl_pkg::PAYLOAD_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  evl_stream_if.sink   in_i,
  evl_stream_if.source out_o
);
  import evl_pkg::*;

  localparam int SLOT_W = $clog2(RING_DEPTH);
  localparam int MEM_W  = PAYLOAD_BITS + 2;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MOD  = 3'b010,
    ST_READ = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Ledger and generation state.
  logic [31:0] wc_q, wc_d;
  logic [31:0] rc_q, rc_d;
  logic [31:0] drop_q, drop_d;
  logic [31:0] gen_q, gen_d;
  logic [31:0] sgen_q, sgen_d;
  logic [31:0] fgen_q, fgen_d;
  logic [31:0] mgen_q, mgen_d;
  logic [31:0] ggen_q, ggen_d;
  logic [31:0] ann_q, ann_d;
  logic [31:0] pend_q, pend_d;
  logic        bound_q, bound_d;
  logic [31:0] base_q, base_d;
  logic [SLOT_W-1:0] wr_slot_q, wr_slot_d;
  logic        filled_q, filled_d;

  logic        out_valid_q, out_valid_d;
  evl_res_t    out_data_q, out_data_d;

  // Ring memory and its registered read port.
  logic [MEM_W-1:0]  ring_mem [RING_DEPTH];
  logic [MEM_W-1:0]  rd_data_q;
  logic              rd_hit_q, rd_hit_d;
  logic              rd_en;
  logic              mem_we;
  logic [MEM_W-1:0]  mem_wdata;

  evl_cmd_t          cmd;
  logic              accept;
  logic              out_free;
  logic              mod_start;
  evl_mod_stat_t     mod_stat;
  logic [SLOT_W-1:0] mod_rem;

  logic [PAYLOAD_BITS+31:0] pay_wide;
  logic [PAYLOAD_BITS+31:0] rd_wide;
  logic [31:0]              base_eff, delta, amount;
  logic [32:0]              pend_sum;
  logic                     taken;
  logic [31:0]              lost_out;

  assign cmd       = in_i.data;
  assign out_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && out_free;
  assign accept    = in_i.valid && in_i.ready;
  assign mod_start = accept && (cmd.command == CMD_READ);

  // Payload is masked to the stored width on the way in, extended on the way out.
  assign pay_wide  = {PAYLOAD_BITS'(0), cmd.record_payload};
  assign mem_wdata = {cmd.event_kind, pay_wide[PAYLOAD_BITS-1:0]};
  assign rd_wide   = {32'd0, rd_data_q[PAYLOAD_BITS-1:0]};

  // The first report binds the baseline, so its drop delta is zero.
  assign base_eff = bound_q ? base_q : cmd.source_dropped_total;
  assign delta    = cmd.source_dropped_total - base_eff;
  assign amount   = (cmd.source_lost > delta) ? cmd.source_lost : delta;
  assign pend_sum = {1'b0, pend_q} + {1'b0, amount};

  evl_mod_unit #(
    .RING_DEPTH(RING_DEPTH)
  ) u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mod_start),
    .value_i(cmd.cursor_value),
    .stat_o (mod_stat),
    .rem_o  (mod_rem)
  );

  always_comb begin
    state_d     = state_q;
    wc_d        = wc_q;
    rc_d        = rc_q;
    drop_d      = drop_q;
    gen_d       = gen_q;
    sgen_d      = sgen_q;
    fgen_d      = fgen_q;
    mgen_d      = mgen_q;
    ggen_d      = ggen_q;
    ann_d       = ann_q;
    pend_d      = pend_q;
    bound_d     = bound_q;
    base_d      = base_q;
    wr_slot_d   = wr_slot_q;
    filled_d    = filled_q;
    rd_hit_d    = rd_hit_q;
    rd_en       = 1'b0;
    mem_we      = 1'b0;
    taken       = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;

    if (accept && (cmd.command != CMD_READ)) begin
      case (cmd.command)
        CMD_APPEND: begin
          // A full ring drops its oldest record.
          if ((wc_q - rc_q) >= 32'(RING_DEPTH)) begin
            rc_d   = rc_q + 32'd1;
            drop_d = drop_q + 32'd1;
          end
          mem_we = 1'b1;
          wc_d   = wc_q + 32'd1;
          if (wr_slot_q == SLOT_W'(RING_DEPTH - 1)) begin
            filled_d = 1'b1;
          end
          // The slot follows the cursor modulo depth, also across the 32-bit wrap.
          if ((wc_q == 32'hFFFF_FFFF) || (wr_slot_q == SLOT_W'(RING_DEPTH - 1))) begin
            wr_slot_d = '0;
          end else begin
            wr_slot_d = wr_slot_q + SLOT_W'(1);
          end
          case (cmd.event_kind)
            KIND_WINDOW: begin
              sgen_d = sgen_q + 32'd1;
              gen_d  = gen_q + 32'd1;
            end
            KIND_FRONT: begin
              sgen_d = sgen_q + 32'd1;
              fgen_d = fgen_q + 32'd1;
              gen_d  = gen_q + 32'd1;
            end
            KIND_MENU: begin
              mgen_d = mgen_q + 32'd1;
              gen_d  = gen_q + 32'd1;
            end
            default: begin
            end
          endcase
        end
        CMD_REPORT: begin
          bound_d = 1'b1;
          base_d  = cmd.source_dropped_total;
          if (amount != 32'd0) begin
            gen_d  = gen_q + 32'd1;
            sgen_d = sgen_q + 32'd1;
            fgen_d = fgen_q + 32'd1;
            mgen_d = mgen_q + 32'd1;
            ggen_d = ggen_q + 32'd1;
            pend_d = pend_sum[32] ? 32'hFFFF_FFFF : pend_sum[31:0];
            drop_d = drop_q + amount;
          end
        end
        CMD_TAKE: begin
          if (gen_q != ann_q) begin
            taken  = 1'b1;
            ann_d  = gen_q;
            pend_d = '0;
          end
        end
        CMD_COMMIT: begin
          if (bound_q && ((cmd.cursor_value - rc_q) <= (wc_q - rc_q))) begin
            rc_d = cmd.cursor_value;
          end
        end
        default: begin
        end
      endcase
      if (accept && cmd.command == CMD_READ) begin
        state_d = ST_MOD;
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (mod_start) begin
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_stat.done) begin
          rd_en    = 1'b1;
          rd_hit_d = filled_q || (mod_rem < wr_slot_q);
          state_d  = ST_READ;
        end
      end
      ST_READ: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    lost_out = (cmd.command == CMD_TAKE) ? pend_q : pend_d;

    if (accept && (cmd.command != CMD_READ)) begin
      out_valid_d                = 1'b1;
      out_data_d.taken           = taken;
      out_data_d.generation      = gen_d;
      out_data_d.structure_gen   = sgen_d;
      out_data_d.front_gen       = fgen_d;
      out_data_d.menu_gen        = mgen_d;
      out_data_d.gap_gen         = ggen_d;
      out_data_d.lost_count      = lost_out;
      out_data_d.write_pos       = wc_d;
      out_data_d.read_pos        = rc_d;
      out_data_d.dropped_count   = drop_d;
      out_data_d.entry_kind      = '0;
      out_data_d.entry_payload   = '0;
    end else if ((state_q == ST_READ) && out_free) begin
      // A read changes no state, so the status comes straight from the registers.
      out_valid_d                = 1'b1;
      out_data_d.taken           = 1'b0;
      out_data_d.generation      = gen_q;
      out_data_d.structure_gen   = sgen_q;
      out_data_d.front_gen       = fgen_q;
      out_data_d.menu_gen        = mgen_q;
      out_data_d.gap_gen         = ggen_q;
      out_data_d.lost_count      = pend_q;
      out_data_d.write_pos       = wc_q;
      out_data_d.read_pos        = rc_q;
      out_data_d.dropped_count   = drop_q;
      out_data_d.entry_kind      = rd_hit_q ? rd_data_q[MEM_W-1 -: 2] : '0;
      out_data_d.entry_payload   = rd_hit_q ? rd_wide[31:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wc_q        <= '0;
      rc_q        <= '0;
      drop_q      <= '0;
      gen_q       <= '0;
      sgen_q      <= '0;
      fgen_q      <= '0;
      mgen_q      <= '0;
      ggen_q      <= '0;
      ann_q       <= '0;
      pend_q      <= '0;
      bound_q     <= 1'b0;
      base_q      <= '0;
      wr_slot_q   <= '0;
      filled_q    <= 1'b0;
      rd_hit_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wc_q        <= wc_d;
      rc_q        <= rc_d;
      drop_q      <= drop_d;
      gen_q       <= gen_d;
      sgen_q      <= sgen_d;
      fgen_q      <= fgen_d;
      mgen_q      <= mgen_d;
      ggen_q      <= ggen_d;
      ann_q       <= ann_d;
      pend_q      <= pend_d;
      bound_q     <= bound_d;
      base_q      <= base_d;
      wr_slot_q   <= wr_slot_d;
      filled_q    <= filled_d;
      rd_hit_q    <= rd_hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  // Ring memory: one write port for appends, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[wr_slot_q] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= ring_mem[mod_rem];
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

// ===== src/evl_checker.sv =====
// Port-level checker for the event ledger ring and its bind to the top level.
`timescale 1ns / 1ps

module evl_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic [2:0]        in_command_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input evl_pkg::evl_res_t out_data_i
);
  import evl_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed or vanished");

  // No command is taken while a finished result is stuck.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("command accepted while the output register was full");

  // Commands other than a read produce their result in the next cycle.
  a_fast_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_command_i != CMD_READ) |=> out_valid_i)
    else $error("single-cycle command gave no result");

  // A read keeps the block busy while its slot is looked up.
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_command_i == CMD_READ) |=> !in_ready_i)
    else $error("command accepted during a read lookup");

endmodule

bind event_ledger_ring_with_generations evl_checker u_evl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_command_i(in_i.data.command),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
